>>> rtl/core/skat_pkg.sv
// shared types, constants and request codes for the sorted key accumulate table
package skat_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_SEGS_DEF  = 4;
  localparam int SEG_WIDTH_DEF = 32;
  localparam int IO_SEGS       = 4;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [2:0] {
    REQ_ACC   = 3'd0,
    REQ_LOOK  = 3'd1,
    REQ_READ  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  localparam logic CFG_KEY_SEGMENTS = 1'b0;
  localparam logic CFG_SET_MODE     = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        key_seg0;
    logic [31:0]        key_seg1;
    logic [31:0]        key_seg2;
    logic [31:0]        key_seg3;
    logic signed [31:0] value_in;
    logic [7:0]         index_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         index_out;
    logic signed [31:0] value_out;
    logic [31:0]        key_out0;
    logic [31:0]        key_out1;
    logic [31:0]        key_out2;
    logic [31:0]        key_out3;
    logic [8:0]         entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset search bounds
    logic probe;     // issue memory read at mid
    logic step;      // narrow bounds using read data
    logic chk_rd;    // read at lo for final hit check
    logic hit_upd;   // write accumulated value at lo
    logic sh_rd;     // read entry ptr-1
    logic sh_wr;     // write read entry to ptr, decrement ptr
    logic ins;       // write new entry at lo, bump count
    logic idx_rd;    // read at index_in
    logic idx_wr;    // write value_in at index_in
    logic clear;     // count to zero
    logic fin;       // load result register
    logic [1:0] fin_sel; // 0 entry, 1 zero fields
    logic [1:0] fin_st;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       search_done;
    logic       hit;
    logic       full;
    logic       shift_done;
    logic       idx_ok;
  } sts_t;

endpackage

>>> rtl/core/sorted_key_accumulate_table.sv
// top level of the sorted key accumulate table
// Keeps up to CAPACITY entries sorted by key; each request gives one result.
// A search does one memory read and one bound update per probe; an insert then shifts
// every entry above the insert point up by one, a read and a write per entry; index
// reads and writes address the entry directly. A new request is taken only in idle.
// The single read and write port of the entry memory sets this pacing.
// No clearing pass: entries at or above the fill count are never used as hits or index results.
module sorted_key_accumulate_table import skat_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_SEGS  = KEY_SEGS_DEF,
  parameter int SEG_WIDTH = SEG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data
);
  logic [2:0] key_segments_r;
  logic       set_mode_r;
  cmd_t       cmd;
  sts_t       sts;

  // config transfer always taken
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_segments_r <= 3'd4;
      set_mode_r     <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_KEY_SEGMENTS) key_segments_r <= cfg_data[2:0];
      else set_mode_r <= cfg_data[0];
    end
  end

  skat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  skat_datapath #(.CAPACITY(CAPACITY), .KEY_SEGS(KEY_SEGS), .SEG_WIDTH(SEG_WIDTH)) u_dp (
    .clk, .rst_n, .in_item(in_data), .key_segments(key_segments_r),
    .set_mode(set_mode_r), .cmd, .sts, .res(out_data)
  );

endmodule

>>> rtl/core/skat_datapath.sv
// datapath: entry memories, search bounds, shift pointer, saturating add, result register
module skat_datapath import skat_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_SEGS  = KEY_SEGS_DEF,
  parameter int SEG_WIDTH = SEG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic [2:0] key_segments,
  input  logic      set_mode,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t res
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = KEY_SEGS * SEG_WIDTH;
  localparam int NIO = (KEY_SEGS < IO_SEGS) ? KEY_SEGS : IO_SEGS;
  localparam int CWS = (SEG_WIDTH < 32) ? SEG_WIDTH : 32;

  logic [KW-1:0] key_mem [CAPACITY];
  logic [31:0]   val_mem [CAPACITY];

  in_item_t      req_r;
  logic [KW-1:0] probe_r;
  logic [3:0]    nseg_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, ptr_r, mid_r;
  logic [KW-1:0] rkey_r;
  logic [31:0]   rval_r;
  logic [AW-1:0] raddr_r;

  // probe key from input fields, unused segments zero
  logic [KW-1:0] probe_c;
  logic [3:0]    nseg_c;
  always_comb begin
    logic [31:0] segs [IO_SEGS];
    segs[0] = in_item.key_seg0;
    segs[1] = in_item.key_seg1;
    segs[2] = in_item.key_seg2;
    segs[3] = in_item.key_seg3;
    nseg_c = {1'b0, key_segments};
    if (nseg_c == 4'd0) nseg_c = 4'd1;
    if (nseg_c > 4'(KEY_SEGS)) nseg_c = 4'(KEY_SEGS);
    probe_c = '0;
    for (int s = 0; s < NIO; s++) begin
      if (4'(s) < nseg_c)
        probe_c[KW-1-s*SEG_WIDTH -: SEG_WIDTH] = SEG_WIDTH'(segs[s][CWS-1:0]);
    end
  end

  // lexicographic compare of stored key to probe: mask unused segments
  logic lt_c, eq_c;
  always_comb begin
    logic [KW-1:0] msk;
    msk = '0;
    for (int s = 0; s < KEY_SEGS; s++)
      if (4'(s) < nseg_r) msk[KW-1-s*SEG_WIDTH -: SEG_WIDTH] = '1;
    lt_c = (rkey_r & msk) < (probe_r & msk);
    eq_c = (rkey_r & msk) == (probe_r & msk);
  end

  // saturating accumulate; in set mode a nonzero sum or new value is stored as ONE_Q16
  logic [31:0] acc_c, newv_c;
  always_comb begin
    logic signed [32:0] s;
    s = 33'(signed'(rval_r)) + 33'(req_r.value_in);
    if (s[32] != s[31]) acc_c = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else acc_c = s[31:0];
    if (set_mode && acc_c != 0) acc_c = ONE_Q16;
    newv_c = req_r.value_in;
    if (set_mode && newv_c != 0) newv_c = ONE_Q16;
  end

  logic [CW-1:0] mid_c;
  assign mid_c = lo_r + ((hi_r - lo_r) >> 1);

  // memory read address select
  logic          rd_en;
  logic [AW-1:0] rd_a;
  always_comb begin
    rd_en = 1'b1;
    rd_a  = '0;
    if (cmd.probe)       rd_a = mid_c[AW-1:0];
    else if (cmd.chk_rd) rd_a = lo_r[AW-1:0];
    else if (cmd.sh_rd)  rd_a = AW'(ptr_r - 1'b1);
    else if (cmd.idx_rd) rd_a = AW'(req_r.index_in);
    else rd_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rkey_r  <= key_mem[rd_a];
      rval_r  <= val_mem[rd_a];
      raddr_r <= rd_a;
    end
    if (cmd.sh_wr) begin
      key_mem[ptr_r[AW-1:0]] <= rkey_r;
      val_mem[ptr_r[AW-1:0]] <= rval_r;
    end else if (cmd.ins) begin
      key_mem[lo_r[AW-1:0]] <= probe_r;
      val_mem[lo_r[AW-1:0]] <= newv_c;
    end else if (cmd.hit_upd) begin
      val_mem[lo_r[AW-1:0]] <= acc_c;
    end else if (cmd.idx_wr) begin
      val_mem[AW'(req_r.index_in)] <= req_r.value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_item;
      probe_r <= probe_c;
      nseg_r  <= nseg_c;
      lo_r    <= '0;
      hi_r    <= cnt_r;
      ptr_r   <= cnt_r;
    end
    if (cmd.probe) mid_r <= mid_c;
    if (cmd.step) begin
      if (lt_c) lo_r <= mid_r + 1'b1;
      else hi_r <= mid_r;
    end
    if (cmd.sh_wr) ptr_r <= ptr_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.clear) cnt_r <= '0;
    else if (cmd.ins) cnt_r <= cnt_r + 1'b1;
  end

  assign sts.req         = req_r.req_type;
  assign sts.search_done = (lo_r >= hi_r);
  assign sts.hit         = (lo_r < cnt_r) && eq_c;
  assign sts.full        = (cnt_r >= CW'(CAPACITY));
  assign sts.shift_done  = (ptr_r <= lo_r);
  assign sts.idx_ok      = (CW'(req_r.index_in) < cnt_r) && (32'(req_r.index_in) < CAPACITY);

  // result fields: entry from read data, or all zero apart from status and count
  out_item_t res_c;
  always_comb begin
    logic [31:0] ko [IO_SEGS];
    for (int s = 0; s < IO_SEGS; s++) ko[s] = '0;
    for (int s = 0; s < NIO; s++)
      ko[s] = 32'(rkey_r[KW-1-s*SEG_WIDTH -: SEG_WIDTH]);
    res_c             = '0;
    res_c.status      = cmd.fin_st;
    res_c.entry_count = 9'(cnt_r);
    if (cmd.fin_sel == 2'd0) begin
      res_c.index_out = 8'(raddr_r);
      res_c.value_out = rval_r;
      res_c.key_out0  = ko[0];
      res_c.key_out1  = ko[1];
      res_c.key_out2  = ko[2];
      res_c.key_out3  = ko[3];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) res <= res_c;
  end

endmodule

>>> rtl/core/skat_ctrl.sv
// controller state machine sequencing search, shift, insert, index access, clear and result
module skat_ctrl import skat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SRCH  = 12'b000000000010,
    S_STEP  = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_DEC   = 12'b000000010000,
    S_SHRD  = 12'b000000100000,
    S_SHWR  = 12'b000001000000,
    S_RDBK  = 12'b000010000000,
    S_FIN   = 12'b000100000000,
    S_IDX   = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_FIN2  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  // next input taken only in idle and when result register is empty or being drained
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        case (sts.req)
          REQ_ACC, REQ_LOOK: state_nxt = S_SRCH;
          REQ_READ, REQ_WRITE: begin
            cmd.idx_rd = 1'b1;
            state_nxt  = S_IDX;
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SRCH: begin
        if (sts.search_done) begin
          cmd.chk_rd = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SRCH;
      end
      S_CHK: begin
        if (sts.hit) begin
          if (sts.req == REQ_ACC) begin
            // write the sum, then read it back for the result
            cmd.hit_upd = 1'b1;
            state_nxt   = S_FIN;
          end else begin
            cmd.fin   = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (sts.req != REQ_ACC) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = 2'd1;
          cmd.fin_st  = ST_NOTFOUND;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end else if (sts.full) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = 2'd1;
          cmd.fin_st  = ST_FULL;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sts.shift_done) begin
          cmd.ins    = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_FIN: begin
        cmd.chk_rd = 1'b1;
        state_nxt  = S_RDBK;
      end
      S_FIN2: begin
        // read back the entry just written by index
        cmd.idx_rd = 1'b1;
        state_nxt  = S_RDBK;
      end
      S_RDBK: begin
        cmd.fin   = 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDX: begin
        if (!sts.idx_ok) begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = 2'd1;
          cmd.fin_st  = ST_NOTFOUND;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end else if (sts.req == REQ_WRITE) begin
          cmd.idx_wr = 1'b1;
          state_nxt  = S_FIN2;
        end else begin
          cmd.fin   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        cmd.fin     = 1'b1;
        cmd.fin_sel = 2'd1;
        ov_nxt      = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_one_cmd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.sh_wr, cmd.ins, cmd.idx_wr}) <= 1) else $error("two writes in one cycle");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> state_r == S_IDLE && out_valid) else $error("result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");

endmodule
